FILE: sv/plgc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plgc_pkg
// Shared types and constants for the piecewise-linear gain curve.
// ----------------------------------------------------------------------------
package plgc_pkg;

  localparam int MAX_POINTS = 6;
  localparam int NUM_POINT_REGS = 6;
  localparam int PTR_W = $clog2(NUM_POINT_REGS);
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_FIRST = 3'd1;

  localparam logic [2:0] MAX_POINTS_3 = 3'(MAX_POINTS);

  localparam logic [23:0] UNITY_GAIN = 24'd25600;

  localparam logic [2:0] FOUND_FEW    = 3'd0;
  localparam logic [2:0] FOUND_BELOW  = 3'd1;
  localparam logic [2:0] FOUND_ABOVE  = 3'd2;
  localparam logic [2:0] FOUND_INTERP = 3'd3;
  localparam logic [2:0] FOUND_NONE   = 3'd4;

  // Quotient bits produced by the serial divider, one per cycle.
  localparam int DIV_STEPS = 24;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int NUM_W = 40;

  typedef struct packed {
    logic [15:0] y;
    logic [15:0] x;
  } point_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [15:0]       den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [23:0] quo;
  } div_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SEARCH,
    S_MUL0,
    S_MUL1,
    S_DIVGO,
    S_DIV
  } state_t;

endpackage
`default_nettype wire

FILE: sv/plgc_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plgc_regs
// Configuration registers: point count and six curve points, one read port.
// ----------------------------------------------------------------------------
module plgc_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [plgc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                  cfg_data,
  input  wire logic [plgc_pkg::PTR_W-1:0]   rd_idx,
  output plgc_pkg::point_t                  rd_point,
  output logic [2:0]                        point_count
);

  plgc_pkg::point_t points [plgc_pkg::NUM_POINT_REGS];
  logic [plgc_pkg::CFG_IDX_W-1:0] wr_slot;

  assign cfg_ready = 1'b1;
  assign wr_slot = cfg_index - plgc_pkg::REG_POINT_FIRST;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= 3'd0;
      for (int i = 0; i < plgc_pkg::NUM_POINT_REGS; i++) begin
        points[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == plgc_pkg::REG_POINT_COUNT) begin
        point_count <= cfg_data[2:0];
      end else if (32'(cfg_index) <= 32'(plgc_pkg::NUM_POINT_REGS)) begin
        points[wr_slot[plgc_pkg::PTR_W-1:0]] <= cfg_data;
      end
    end
  end

  assign rd_point = points[rd_idx];

endmodule
`default_nettype wire

FILE: sv/plgc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plgc_div
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits in 24 bits.
// ----------------------------------------------------------------------------
module plgc_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  plgc_pkg::div_req_t      req,
  output plgc_pkg::div_rsp_t      rsp
);

  logic                            running;
  logic                            finished;
  logic [plgc_pkg::DIV_CNT_W-1:0]  cnt;
  logic [15:0]                     rem;
  logic [15:0]                     den;
  logic [23:0]                     quo;
  logic [16:0]                     shifted;
  logic [16:0]                     diff;
  logic                            fits;

  assign shifted = {rem, quo[23]};
  assign diff    = shifted - {1'b0, den};
  assign fits    = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      cnt      <= '0;
      finished <= 1'b0;
    end else begin
      finished <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == plgc_pkg::DIV_CNT_W'(plgc_pkg::DIV_STEPS - 1)) begin
          running  <= 1'b0;
          finished <= 1'b1;
        end
      end
    end
  end

  // The upper numerator bits are below the divisor, so the remainder
  // always fits in sixteen bits.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.num[39:24];
      quo <= req.num[23:0];
      den <= req.den;
    end else if (running) begin
      rem <= fits ? diff[15:0] : shifted[15:0];
      quo <= {quo[22:0], fits};
    end
  end

  assign rsp = {finished, quo};

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !running)
    else $error("divider started while running");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    running |-> 32'(cnt) < plgc_pkg::DIV_STEPS)
    else $error("divider step count out of range");

  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> $past(running))
    else $error("divider done without a division in flight");

endmodule
`default_nettype wire

FILE: sv/piecewise_linear_gain_curve.sv
`default_nettype none
// ----------------------------------------------------------------------------
// piecewise_linear_gain_curve
// Evaluates a curve of up to six points at a magnitude, giving a gain in
// percent with 8 fractional bits.
//
//   channel   signals                               direction
//   input     start, busy, magnitude                in (busy out)
//   result    done, gain, how_found                 out
//   config    cfg_valid, cfg_ready, cfg_index,      in (cfg_ready out)
//             cfg_data
//
// An item is taken when start is high and busy is low; the result appears
// in the cycle after the last working cycle, with done high for one cycle.
// Clamped results come from the first and last point checks, a segment
// search reads the points in turn, and an interpolation adds the multiply
// states S_MUL0 and S_MUL1 and the serial divide in S_DIVGO and S_DIV.
// Synchronous reset clears the configuration registers to zero and the sequencer to idle.
// The receiver cannot stall; a new item may be started in the done cycle.
// ----------------------------------------------------------------------------
module piecewise_linear_gain_curve (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [9:0]                     magnitude,
  output logic                                done,
  output logic [23:0]                         gain,
  output logic [2:0]                          how_found,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [plgc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data
);

  plgc_pkg::state_t state, state_next;
  logic [15:0] mag, mag_next;
  logic [2:0]  n, n_next;
  logic [plgc_pkg::PTR_W-1:0] ptr, ptr_next;
  plgc_pkg::point_t prev, prev_next;
  plgc_pkg::point_t hi, hi_next;
  logic [31:0] prod, prod_next;
  logic [31:0] acc, acc_next;
  logic        done_next;
  logic [23:0] gain_next;
  logic [2:0]  how_found_next;

  plgc_pkg::point_t rd_point;
  logic [2:0]  point_count;
  logic [15:0] mul_a, mul_b;
  logic [31:0] sum;
  plgc_pkg::div_req_t div_req;
  plgc_pkg::div_rsp_t div_rsp;

  plgc_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rd_idx     (ptr),
    .rd_point   (rd_point),
    .point_count(point_count)
  );

  plgc_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  // One shared multiplier: left weight first, then right weight.
  always_comb begin
    if (state == plgc_pkg::S_MUL0) begin
      mul_a = prev.y;
      mul_b = hi.x - mag;
    end else begin
      mul_a = hi.y;
      mul_b = mag - prev.x;
    end
  end

  // Both weighted terms together stay at or below 65535 times the segment width.
  assign sum = acc + prod;

  assign div_req = {(state == plgc_pkg::S_DIVGO), sum, 8'h00, 16'(hi.x - prev.x)};

  assign busy = (state != plgc_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plgc_pkg::S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    mag       <= mag_next;
    n         <= n_next;
    ptr       <= ptr_next;
    prev      <= prev_next;
    hi        <= hi_next;
    prod      <= prod_next;
    acc       <= acc_next;
    gain      <= gain_next;
    how_found <= how_found_next;
  end

  always_comb begin
    state_next     = state;
    mag_next       = mag;
    n_next         = n;
    ptr_next       = ptr;
    prev_next      = prev;
    hi_next        = hi;
    prod_next      = prod;
    acc_next       = acc;
    done_next      = 1'b0;
    gain_next      = gain;
    how_found_next = how_found;

    unique case (state)
      plgc_pkg::S_IDLE: begin
        ptr_next = '0;
        if (start) begin
          mag_next   = {6'd0, magnitude};
          n_next     = (point_count > plgc_pkg::MAX_POINTS_3) ?
                       plgc_pkg::MAX_POINTS_3 : point_count;
          state_next = plgc_pkg::S_FIRST;
        end
      end
      plgc_pkg::S_FIRST: begin
        if (n < 3'd2) begin
          gain_next      = plgc_pkg::UNITY_GAIN;
          how_found_next = plgc_pkg::FOUND_FEW;
          done_next      = 1'b1;
          state_next     = plgc_pkg::S_IDLE;
        end else if (mag <= rd_point.x) begin
          gain_next      = {rd_point.y, 8'h00};
          how_found_next = plgc_pkg::FOUND_BELOW;
          done_next      = 1'b1;
          state_next     = plgc_pkg::S_IDLE;
        end else begin
          prev_next  = rd_point;
          ptr_next   = plgc_pkg::PTR_W'(n - 3'd1);
          state_next = plgc_pkg::S_LAST;
        end
      end
      plgc_pkg::S_LAST: begin
        if (mag >= rd_point.x) begin
          gain_next      = {rd_point.y, 8'h00};
          how_found_next = plgc_pkg::FOUND_ABOVE;
          done_next      = 1'b1;
          state_next     = plgc_pkg::S_IDLE;
        end else begin
          ptr_next   = plgc_pkg::PTR_W'(1);
          state_next = plgc_pkg::S_SEARCH;
        end
      end
      plgc_pkg::S_SEARCH: begin
        // prev holds the left end of the segment, rd_point its right end.
        if (mag >= prev.x && mag <= rd_point.x) begin
          if (rd_point.x == prev.x) begin
            gain_next      = {prev.y, 8'h00};
            how_found_next = plgc_pkg::FOUND_INTERP;
            done_next      = 1'b1;
            state_next     = plgc_pkg::S_IDLE;
          end else begin
            hi_next    = rd_point;
            state_next = plgc_pkg::S_MUL0;
          end
        end else begin
          prev_next = rd_point;
          if (3'(ptr) == n - 3'd1) begin
            gain_next      = plgc_pkg::UNITY_GAIN;
            how_found_next = plgc_pkg::FOUND_NONE;
            done_next      = 1'b1;
            state_next     = plgc_pkg::S_IDLE;
          end else begin
            ptr_next = ptr + 1'b1;
          end
        end
      end
      plgc_pkg::S_MUL0: begin
        prod_next  = 32'(mul_a) * 32'(mul_b);
        state_next = plgc_pkg::S_MUL1;
      end
      plgc_pkg::S_MUL1: begin
        acc_next   = prod;
        prod_next  = 32'(mul_a) * 32'(mul_b);
        state_next = plgc_pkg::S_DIVGO;
      end
      plgc_pkg::S_DIVGO: begin
        state_next = plgc_pkg::S_DIV;
      end
      plgc_pkg::S_DIV: begin
        if (div_rsp.done) begin
          gain_next      = div_rsp.quo;
          how_found_next = plgc_pkg::FOUND_INTERP;
          done_next      = 1'b1;
          state_next     = plgc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = plgc_pkg::S_IDLE;
      end
    endcase
  end

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item accepted but sequencer did not start");

  a_done_from_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without an item in progress");

  a_nonzero_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == plgc_pkg::S_DIVGO) |-> (hi.x != prev.x))
    else $error("divide started on a zero-width segment");

  a_how_code: assert property (@(posedge clk) disable iff (rst)
    (done && how_found == plgc_pkg::FOUND_FEW) |-> gain == plgc_pkg::UNITY_GAIN)
    else $error("too few points but gain is not unity");

endmodule
`default_nettype wire

FILE: bench/plgc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plgc_checker
// Watches the input, result and register channels of the gain curve. It keeps
// its own copy of the curve registers, works out the gain and lookup kind for
// every accepted item, and compares each result with the oldest one waiting.
// ----------------------------------------------------------------------------
module plgc_checker
  import plgc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic                 busy,
  input  wire logic [9:0]           magnitude,
  input  wire logic                 done,
  input  wire logic [23:0]          gain,
  input  wire logic [2:0]           how_found,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  output int                        mismatches,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [9:0]  mag;
    logic [23:0] gain;
    logic [2:0]  how;
  } gain_lookup_t;

  logic [2:0]   curve_len;
  point_t       curve [NUM_POINT_REGS];
  gain_lookup_t gains_due [$];

  initial begin
    mismatches = 0;
    pending = 0;
  end

  function automatic gain_lookup_t lookup_gain(logic [9:0] mag);
    gain_lookup_t r;
    int           n;
    bit           found;
    longint       x0, x1, y0, y1, dx, num;
    r.mag = mag;
    r.gain = UNITY_GAIN;
    r.how = FOUND_FEW;
    n = (curve_len > MAX_POINTS_3) ? MAX_POINTS : int'(curve_len);
    if (n >= 2) begin
      if (mag <= curve[0].x) begin
        r.gain = {curve[0].y, 8'd0};
        r.how = FOUND_BELOW;
      end else if (mag >= curve[n-1].x) begin
        r.gain = {curve[n-1].y, 8'd0};
        r.how = FOUND_ABOVE;
      end else begin
        r.how = FOUND_NONE;
        found = 1'b0;
        for (int i = 0; i + 1 < n && !found; i++) begin
          if (mag >= curve[i].x && mag <= curve[i+1].x) begin
            found = 1'b1;
            r.how = FOUND_INTERP;
            if (curve[i].x == curve[i+1].x) begin
              r.gain = {curve[i].y, 8'd0};
            end else begin
              x0 = curve[i].x;
              x1 = curve[i+1].x;
              y0 = curve[i].y;
              y1 = curve[i+1].y;
              dx = x1 - x0;
              num = y0 * 256 * dx + (longint'(mag) - x0) * (y1 - y0) * 256;
              if (num < 0) num = 0;
              r.gain = 24'(num / dx);
            end
          end
        end
      end
    end
    return r;
  endfunction

  task automatic flag(string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    gain_lookup_t due;
    if (rst) begin
      curve_len = '0;
      for (int k = 0; k < NUM_POINT_REGS; k++) curve[k] = '0;
      gains_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_POINT_COUNT) begin
          curve_len = cfg_data[2:0];
        end else if (cfg_index >= REG_POINT_FIRST &&
                     cfg_index < REG_POINT_FIRST + NUM_POINT_REGS) begin
          curve[cfg_index - REG_POINT_FIRST] = cfg_data;
        end
      end
      // A new item may be taken in the same cycle as a result, so the
      // result is matched before the new expectation is queued.
      if (done) begin
        if (gains_due.size() == 0) begin
          flag($sformatf("result with no item outstanding: gain %0d how_found %0d",
                         gain, how_found));
        end else begin
          due = gains_due.pop_front();
          if (gain !== due.gain)
            flag($sformatf("gain for magnitude %0d: expected %0d, got %0d",
                           due.mag, due.gain, gain));
          if (how_found !== due.how)
            flag($sformatf("how_found for magnitude %0d: expected %0d, got %0d",
                           due.mag, due.how, how_found));
        end
      end
      if (start && !busy) gains_due.push_back(lookup_gain(magnitude));
    end
    pending = gains_due.size();
  end

endmodule
`default_nettype wire

FILE: bench/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Drives the gain curve with a short directed set of curves and magnitudes,
// then with random curves and magnitudes under three sender idling regimes.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import plgc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
  localparam int IDLE_LIGHT = 7;
  localparam int IDLE_HEAVY = 57;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_CURVES = 12;
  localparam int ITEMS_PER_CURVE = 52;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic [9:0]           magnitude = '0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  logic                 busy, done, cfg_ready;
  logic [23:0]          gain;
  logic [2:0]           how_found;
  int                   mismatches, pending;

  logic item_took = 1'b0;
  logic cfg_took = 1'b0;
  logic [31:0] curve_words [NUM_POINT_REGS];
  int items_sent = 0;
  int curves_loaded = 0;

  piecewise_linear_gain_curve uut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .magnitude(magnitude),
    .done(done), .gain(gain), .how_found(how_found),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  plgc_checker chk (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .magnitude(magnitude),
    .done(done), .gain(gain), .how_found(how_found),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Handshakes are recorded at the rising edge and read back at the falling one.
  always @(posedge clk) begin
    item_took <= start && !busy && !rst;
    cfg_took <= cfg_valid && cfg_ready && !rst;
  end

  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(negedge clk); while (!cfg_took);
  endtask

  task automatic load_curve(input logic [2:0] count);
    for (int k = 0; k < NUM_POINT_REGS; k++)
      write_reg(REG_POINT_FIRST + 3'(k), curve_words[k]);
    write_reg(REG_POINT_COUNT, {29'($urandom()), count});
    write_reg(CFG_IDX_UNUSED, $urandom());
    cfg_valid = 1'b0;
    curves_loaded++;
  endtask

  task automatic settle();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_item(input logic [9:0] mag, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    magnitude = mag;
    do @(negedge clk); while (!item_took);
    items_sent++;
  endtask

  // Mostly ascending curves with occasional repeated x; some non-ascending or
  // fully random words, and y values that hit both ends of their range.
  task automatic draw_curve();
    int          style;
    logic [15:0] x, y;
    style = $urandom_range(0, 9);
    x = 16'($urandom_range(0, 200));
    for (int k = 0; k < NUM_POINT_REGS; k++) begin
      if (style == 0) begin
        curve_words[k] = $urandom();
      end else begin
        if (style == 1) x = 16'($urandom_range(0, 1023));
        else if (k > 0 && $urandom_range(0, 7) != 0) x = x + 16'($urandom_range(0, 300));
        case ($urandom_range(0, 5))
          0: y = 16'h0000;
          1: y = 16'hFFFF;
          default: y = 16'($urandom_range(0, 400));
        endcase
        curve_words[k] = {y, x};
      end
    end
  endtask

  function automatic logic [9:0] draw_magnitude();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 7) return 10'($urandom_range(1001, 1023));
    if (pick >= 8)
      return 10'(curve_words[$urandom_range(0, NUM_POINT_REGS-1)][15:0] +
                 16'($urandom_range(0, 2)) - 16'd1);
    return 10'($urandom_range(0, 1000));
  endfunction

  initial begin
    int         idle_pct;
    logic [2:0] count;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset curve: too few points.
    send_item(10'd0, 0);
    send_item(10'd1000, 0);
    send_item(10'd1023, 0);
    send_item(10'd512, 0);
    settle();

    // Count above the limit, a repeated x, and y at both extremes.
    curve_words = '{{16'd0, 16'd100}, {16'd65535, 16'd250}, {16'd1000, 16'd250},
                    {16'd300, 16'd400}, {16'd300, 16'd700}, {16'd120, 16'd1000}};
    load_curve(3'd7);
    send_item(10'd0, IDLE_LIGHT);
    send_item(10'd100, IDLE_LIGHT);
    send_item(10'd101, IDLE_LIGHT);
    send_item(10'd175, IDLE_LIGHT);
    send_item(10'd250, IDLE_LIGHT);
    send_item(10'd251, IDLE_LIGHT);
    send_item(10'd399, IDLE_LIGHT);
    send_item(10'd400, IDLE_LIGHT);
    send_item(10'd550, IDLE_LIGHT);
    send_item(10'd700, IDLE_LIGHT);
    send_item(10'd999, IDLE_LIGHT);
    send_item(10'd1000, IDLE_LIGHT);
    send_item(10'd1001, IDLE_LIGHT);
    send_item(10'd1023, IDLE_LIGHT);
    settle();

    // A single point still gives unity gain.
    load_curve(3'd1);
    send_item(10'd500, 0);
    settle();

    // Two points sharing an x.
    curve_words[0] = {16'd50, 16'd300};
    curve_words[1] = {16'd80, 16'd300};
    load_curve(3'd2);
    send_item(10'd300, 0);
    send_item(10'd301, 0);
    settle();

    // Points that fall back before rising again.
    curve_words[0] = {16'd10, 16'd100};
    curve_words[1] = {16'd20, 16'd50};
    curve_words[2] = {16'd30, 16'd40};
    curve_words[3] = {16'd40, 16'd900};
    load_curve(3'd4);
    send_item(10'd500, 0);
    send_item(10'd899, 0);
    settle();

    for (int s = 0; s < RANDOM_CURVES; s++) begin
      if (s < RANDOM_CURVES / 3) idle_pct = IDLE_LIGHT;
      else if (s < 2 * RANDOM_CURVES / 3) idle_pct = IDLE_HEAVY;
      else idle_pct = 0;
      if (s == 0) begin
        foreach (curve_words[k]) curve_words[k] = 32'hFFFF_FFFF;
        count = 3'd7;
      end else if (s == 1) begin
        foreach (curve_words[k]) curve_words[k] = 32'h0000_0000;
        count = 3'd6;
      end else begin
        draw_curve();
        count = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                            : 3'($urandom_range(2, 7));
      end
      load_curve(count);
      for (int i = 0; i < ITEMS_PER_CURVE; i++) send_item(draw_magnitude(), idle_pct);
      settle();
    end

    $display("Sent %0d magnitudes over %0d curve settings,", items_sent, curves_loaded);
    $display("with light, heavy and no sender idling.");
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
